// ===== rtl/ppr_pkg.sv =====
// Package for the polynomial predictor residual fold block.
// Holds field widths, payload types and the history status struct.
// It depends on nothing else.
package ppr_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ResidW  = 20;
  localparam int unsigned SeenW   = 2;

  localparam logic [SeenW-1:0] SeenMax = 2'd3;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic        [ResidW-1:0]  resid_t;
  typedef logic signed [ResidW-1:0]  wide_t;

  typedef struct packed {
    logic            start_of_stream;
    sample_t         sample_in;
    resid_t          residual_in;
  } item_t;

  typedef struct packed {
    resid_t          residual_out;
    sample_t         sample_out;
  } result_t;

  // History as the current item sees it, newest first.
  typedef struct packed {
    sample_t          a;
    sample_t          b;
    sample_t          c;
    logic [SeenW-1:0] seen;
  } hist_t;

  // Control from the compute stage to the history store.
  typedef struct packed {
    logic    push;
    logic    clear;
    sample_t sample;
  } hist_ctrl_t;

endpackage

// ===== rtl/ppr_if.sv =====
// Handshake interfaces for the input, result and configuration channels.
// Depends on ppr_pkg for the payload types.
interface ppr_in_if;
  logic              valid;
  logic              ready;
  logic              start_of_stream;
  ppr_pkg::sample_t  sample_in;
  ppr_pkg::resid_t   residual_in;

  modport source (output valid, output start_of_stream, output sample_in,
                  output residual_in, input ready);
  modport sink   (input valid, input start_of_stream, input sample_in,
                  input residual_in, output ready);
endinterface

interface ppr_out_if;
  logic              valid;
  logic              ready;
  ppr_pkg::resid_t   residual_out;
  ppr_pkg::sample_t  sample_out;

  modport source (output valid, output residual_out, output sample_out, input ready);
  modport sink   (input valid, input residual_out, input sample_out, output ready);
endinterface

interface ppr_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/polynomial_predictor_residual_fold.sv =====
// Top level of the order-3 polynomial predictor with zigzag residual fold.
// Depends on ppr_pkg, ppr_if, ppr_history and ppr_datapath.
//
// Usage:
//   in_i   carries one item per handshake: start_of_stream, sample_in and
//          residual_in. Set start_of_stream on the first item of a stream.
//   out_o  carries one result item per input item, in order: residual_out
//          in encode mode, sample_out in decode mode, the other field zero.
//   cfg_i  writes the mode bit (0 encode, 1 decode). Write it only while
//          no item is in flight; it is always ready.
// An accepted item is held in the input register, passes the compute stage
// and is loaded into the result register, where the result is then valid.
// Throughput: one item per cycle while the receiver does not stall, set by
// the history feedback loop, which closes within the single compute stage
// between the two registers. Reset clears the mode to encode, empties both
// registers and clears the history. When the receiver stalls, the result
// register holds its item and the input register takes one more;
// in_i.ready then drops until the result is taken.
module polynomial_predictor_residual_fold (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppr_in_if.sink    in_i,
  ppr_out_if.source out_o,
  ppr_cfg_if.sink   cfg_i
);

  logic             mode_q;
  logic             in_vld_q, out_vld_q;
  ppr_pkg::item_t   item_q;
  ppr_pkg::result_t res_q, res_d;
  ppr_pkg::hist_t   hist;
  ppr_pkg::hist_ctrl_t hist_ctrl;
  ppr_pkg::sample_t push_sample;
  logic             out_free, advance, in_fire;

  // Advance a held item whenever the result register is free.
  assign out_free = !out_vld_q || out_o.ready;
  assign advance  = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || advance;
  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ppr_pkg::MODE_ENCODE;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.data;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.start_of_stream <= in_i.start_of_stream;
      item_q.sample_in       <= in_i.sample_in;
      item_q.residual_in     <= in_i.residual_in;
    end
  end

  // History is pushed as the item leaves the compute stage, so the
  // next item already sees it.
  assign hist_ctrl.push   = advance;
  assign hist_ctrl.clear  = item_q.start_of_stream && in_vld_q;
  assign hist_ctrl.sample = push_sample;

  ppr_history u_history (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (hist_ctrl),
    .hist_o (hist)
  );

  ppr_datapath u_datapath (
    .mode_i        (mode_q),
    .item_i        (item_q),
    .hist_i        (hist),
    .result_o      (res_d),
    .push_sample_o (push_sample)
  );

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.residual_out = res_q.residual_out;
  assign out_o.sample_out   = res_q.sample_out;

endmodule

// ===== rtl/ppr_history.sv =====
// Sample history store: three newest samples and a saturating count.
// Depends on ppr_pkg for hist_t and hist_ctrl_t.
module ppr_history (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ppr_pkg::hist_ctrl_t ctrl_i,
  output ppr_pkg::hist_t      hist_o
);

  ppr_pkg::hist_t hist_q, hist_d;

  // A start flag clears the history before the item uses it.
  always_comb begin
    hist_o = ctrl_i.clear ? '0 : hist_q;
  end

  always_comb begin
    hist_d = hist_q;
    if (ctrl_i.push) begin
      hist_d.a = ctrl_i.sample;
      hist_d.b = hist_o.a;
      hist_d.c = hist_o.b;
      hist_d.seen = (hist_o.seen == ppr_pkg::SeenMax) ? ppr_pkg::SeenMax
                                                      : hist_o.seen + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else begin
      hist_q <= hist_d;
    end
  end

endmodule

// ===== rtl/ppr_datapath.sv =====
// Prediction, zigzag fold and unfold for one item.
// Depends on ppr_pkg; purely combinational.
module ppr_datapath (
  input  logic             mode_i,
  input  ppr_pkg::item_t   item_i,
  input  ppr_pkg::hist_t   hist_i,
  output ppr_pkg::result_t result_o,
  output ppr_pkg::sample_t push_sample_o
);

  localparam int unsigned PadW = ppr_pkg::ResidW - ppr_pkg::SampleW;

  ppr_pkg::wide_t a_w, b_w, c_w, s_w, diff_w, pred_w, resid_w, unf_w, rec_w;
  logic [ppr_pkg::ResidW:0] fold_w;
  ppr_pkg::resid_t          half_w;

  always_comb begin
    a_w = {{PadW{hist_i.a[ppr_pkg::SampleW-1]}}, hist_i.a};
    b_w = {{PadW{hist_i.b[ppr_pkg::SampleW-1]}}, hist_i.b};
    c_w = {{PadW{hist_i.c[ppr_pkg::SampleW-1]}}, hist_i.c};
    s_w = {{PadW{item_i.sample_in[ppr_pkg::SampleW-1]}}, item_i.sample_in};
    diff_w = a_w - b_w;

    case (hist_i.seen)
      2'd0:    pred_w = '0;
      2'd1:    pred_w = a_w;
      2'd2:    pred_w = (a_w <<< 1) - b_w;
      default: pred_w = (diff_w <<< 1) + diff_w + c_w;
    endcase

    // Fold: twice the residual, inverted when it is negative.
    resid_w = s_w - pred_w;
    fold_w  = {resid_w, 1'b0} ^ {(ppr_pkg::ResidW+1){resid_w[ppr_pkg::ResidW-1]}};

    // Unfold: halve, invert when odd.
    half_w = {1'b0, item_i.residual_in[ppr_pkg::ResidW-1:1]};
    unf_w  = half_w ^ {ppr_pkg::ResidW{item_i.residual_in[0]}};
    rec_w  = unf_w + pred_w;

    if (mode_i == ppr_pkg::MODE_DECODE) begin
      result_o.residual_out = '0;
      result_o.sample_out   = rec_w[ppr_pkg::SampleW-1:0];
      push_sample_o         = rec_w[ppr_pkg::SampleW-1:0];
    end else begin
      result_o.residual_out = fold_w[ppr_pkg::ResidW-1:0];
      result_o.sample_out   = '0;
      push_sample_o         = item_i.sample_in;
    end
  end

endmodule
